// ----- rtl/ctfs_pkg.sv -----
// shared types and constants for the chat format tag stripper
// no dependencies; imported by every module of the block
package ctfs_pkg;

   localparam int WIN_DEPTH = 7;
   localparam int CNT_W     = 3;
   localparam int NUM_TAGS  = 6;
   localparam int TAG_MAX   = 7;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   localparam logic [7:0] ESC_CHAR = 8'h1b;
   localparam logic [7:0] BRK_CHAR = "[";
   localparam logic [7:0] GT_CHAR  = ">";
   localparam logic [7:0] M_CHAR   = "m";
   localparam logic [7:0] CR_CHAR  = 8'h0d;
   localparam logic [7:0] LF_CHAR  = 8'h0a;
   localparam logic [7:0] NUL_CHAR = 8'h00;

   // lower-case tag heads, unused tail bytes are never compared
   localparam logic [7:0] TAG_CHARS [NUM_TAGS][TAG_MAX] = '{
      '{"<", "f", "o", "n", "t", " ", NUL_CHAR},
      '{"<", "/", "f", "o", "n", "t", NUL_CHAR},
      '{"<", "f", "a", "d", "e", " ", NUL_CHAR},
      '{"<", "/", "f", "a", "d", "e", ">"},
      '{"<", "a", "l", "t", " ", NUL_CHAR, NUL_CHAR},
      '{"<", "/", "a", "l", "t", ">", NUL_CHAR}
   };
   localparam logic [CNT_W-1:0] TAG_LEN [NUM_TAGS] = '{
      CNT_W'(6), CNT_W'(6), CNT_W'(6), CNT_W'(7), CNT_W'(5), CNT_W'(6)
   };

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   typedef enum logic [1:0] {
      SKIP_NONE,
      SKIP_TAG,
      SKIP_ANSI
   } skip_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROC,
      ST_LF,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic tag_hit;
      logic esc_hit;
      logic needs_lf;
   } match_type;

   function automatic logic [7:0] fold(input logic [7:0] b);
      if (b >= "A" && b <= "Z") begin
         return b + 8'h20;
      end
      return b;
   endfunction

endpackage

// ----- rtl/ctfs_cell.sv -----
// one byte slot of the lookahead chain
// depends on ctfs_pkg; takes a new byte or the byte of the next slot, else holds its byte
module ctfs_cell (
   input  logic                    clock,
   input  ctfs_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              in_byte,
   input  logic [7:0]              next_byte,
   output logic [7:0]              data
);
   import ctfs_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      if (ctrl.load) begin
         data_in = in_byte;
      end else if (ctrl.shift) begin
         data_in = next_byte;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/ctfs_matcher.sv -----
// head-of-window pattern detection: tag heads, escape colour start, bare cr
// depends on ctfs_pkg
module ctfs_matcher (
   input  ctfs_pkg::window_type     view,
   input  logic [ctfs_pkg::CNT_W-1:0] count,
   output ctfs_pkg::match_type      match
);
   import ctfs_pkg::*;

   logic [NUM_TAGS-1:0] tag_ok;

   always_comb begin
      for (int k = 0; k < NUM_TAGS; k++) begin
         tag_ok[k] = (count >= TAG_LEN[k]);
         for (int i = 0; i < TAG_MAX; i++) begin
            if (CNT_W'(i) < TAG_LEN[k] && fold(view[i]) != TAG_CHARS[k][i]) begin
               tag_ok[k] = 1'b0;
            end
         end
      end
   end

   assign match.tag_hit  = |tag_ok;
   assign match.esc_hit  = (count >= CNT_TWO) && (view[0] == ESC_CHAR)
                           && (view[1] == BRK_CHAR);
   // after the head is popped, lf is needed unless the new head is lf
   assign match.needs_lf = (view[0] == CR_CHAR)
                           && ((count == CNT_ONE) || (view[1] != LF_CHAR));

endmodule

// ----- rtl/chat_format_tag_stripper_core.sv -----
// top level of the chat format tag stripper: control sequencer, cell chain,
// output stage; depends on ctfs_pkg, ctfs_cell and ctfs_matcher
//
// Bytes enter a seven-slot chain of cells and leave from its head once the
// chain is full, so cleaned output trails the input by six bytes. In steady
// text, while the result channel does not stall, one byte is taken per cycle
// and one byte leaves per cycle; a CR with no LF after it holds the input
// while the inserted LF is sent. A tag or ESC '[' sequence is recognized at
// the head of the chain, then bytes still in the chain are dropped one per
// cycle up to the terminator; bytes arriving while a skip is open are dropped
// on arrival at full rate. The message end (last byte set) drains the chain
// one slot per cycle while the result channel does not stall, with inserted
// LFs and recognized tags or ESC '[' sequences there, then finds the chain
// empty and sends the final result carrying end_of_message, a bare marker
// with byte_valid low when nothing is left to send. A stalled result channel
// holds the block once its output register is full.
module chat_format_tag_stripper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_message
);
   import ctfs_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   skip_type          skip_ff, skip_in;
   logic              ended_ff, ended_in;
   logic              final_ff, final_in;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_bv_ff;
   logic              rsp_eom_ff;
   logic              pend_valid_ff;
   logic [7:0]        pend_byte_ff;

   window_type        win;
   window_type        view;
   logic [CNT_W-1:0]  view_count;
   match_type         match;
   cell_ctrl_type     cell_ctrl [WIN_DEPTH];

   logic              out_free;
   logic              accept;
   logic              append_en;
   logic              fast_full;
   logic              shift;
   logic              append;
   logic [CNT_W-1:0]  load_idx;
   logic              res_req;
   logic [7:0]        res_byte;
   logic              end_req;
   logic              out_load;
   logic              head_term;
   logic              in_term;

   // ---------------- cell chain ----------------
   always_comb begin
      load_idx = shift ? (count_ff - CNT_ONE) : count_ff;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         cell_ctrl[i].shift = shift;
         cell_ctrl[i].load  = append && (load_idx == CNT_W'(i));
      end
   end

   for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
      logic [7:0] next_byte;
      if (g == WIN_DEPTH - 1) begin : g_tail
         assign next_byte = NUL_CHAR;
      end else begin : g_link
         assign next_byte = win[g+1];
      end
      ctfs_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .in_byte   (req_in_byte),
         .next_byte (next_byte),
         .data      (win[g])
      );
   end

   // in idle the incoming byte is looked at as if it were already the tail
   always_comb begin
      view = win;
      view_count = count_ff;
      if (state_ff == ST_IDLE) begin
         view[WIN_DEPTH-1] = req_in_byte;
         view_count = CNT_FULL;
      end
   end

   ctfs_matcher u_matcher (
      .view  (view),
      .count (view_count),
      .match (match)
   );

   // ---------------- shared decode ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign append_en = !ended_ff && (req_in_byte != NUL_CHAR);
   assign fast_full = append_en && (count_ff == CNT_FULL - CNT_ONE);
   assign head_term = ((skip_ff == SKIP_TAG) && (win[0] == GT_CHAR))
                      || ((skip_ff == SKIP_ANSI) && (win[0] == M_CHAR));
   assign in_term   = ((skip_ff == SKIP_TAG) && (req_in_byte == GT_CHAR))
                      || ((skip_ff == SKIP_ANSI) && (req_in_byte == M_CHAR));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_last_byte) begin
                  state_in = ST_PROC;
               end else if (skip_ff != SKIP_NONE) begin
                  state_in = ST_IDLE;
               end else if (fast_full) begin
                  if (match.tag_hit || match.esc_hit) begin
                     state_in = ST_PROC;
                  end else if (match.needs_lf) begin
                     state_in = ST_LF;
                  end
               end
            end
         end
         ST_PROC: begin
            if (count_ff == '0) begin
               state_in = final_ff ? ST_DONE : ST_IDLE;
            end else if (skip_ff != SKIP_NONE) begin
               state_in = ST_PROC;
            end else if (!final_ff && count_ff < CNT_FULL) begin
               state_in = ST_IDLE;
            end else if (match.tag_hit || match.esc_hit) begin
               state_in = ST_PROC;
            end else if (out_free) begin
               if (match.needs_lf) begin
                  state_in = ST_LF;
               end else begin
                  state_in = final_ff ? ST_PROC : ST_IDLE;
               end
            end
         end
         ST_LF: begin
            if (out_free) begin
               state_in = final_ff ? ST_PROC : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs and datapath control ----------------
   always_comb begin
      shift    = 1'b0;
      append   = 1'b0;
      count_in = count_ff;
      skip_in  = skip_ff;
      ended_in = ended_ff;
      final_in = final_ff;
      res_req  = 1'b0;
      res_byte = win[0];
      end_req  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!ended_ff && req_in_byte == NUL_CHAR) begin
                  ended_in = 1'b1;
               end
               if (req_last_byte) begin
                  append   = append_en;
                  count_in = count_ff + CNT_W'(append_en);
                  final_in = 1'b1;
               end else if (skip_ff != SKIP_NONE) begin
                  // window is empty while skipping, the byte is dropped on arrival
                  if (append_en && in_term) begin
                     skip_in = SKIP_NONE;
                  end
               end else if (fast_full) begin
                  if (match.tag_hit || match.esc_hit) begin
                     append   = 1'b1;
                     count_in = CNT_FULL;
                  end else begin
                     shift   = 1'b1;
                     append  = 1'b1;
                     res_req = 1'b1;
                  end
               end else if (append_en) begin
                  append   = 1'b1;
                  count_in = count_ff + CNT_ONE;
               end
            end
         end
         ST_PROC: begin
            if (count_ff == '0) begin
               shift = 1'b0;
            end else if (skip_ff != SKIP_NONE) begin
               shift    = 1'b1;
               count_in = count_ff - CNT_ONE;
               if (head_term) begin
                  skip_in = SKIP_NONE;
               end
            end else if (!final_ff && count_ff < CNT_FULL) begin
               shift = 1'b0;
            end else if (match.tag_hit) begin
               skip_in = SKIP_TAG;
            end else if (match.esc_hit) begin
               skip_in = SKIP_ANSI;
            end else if (out_free) begin
               shift    = 1'b1;
               count_in = count_ff - CNT_ONE;
               res_req  = 1'b1;
            end
         end
         ST_LF: begin
            if (out_free) begin
               res_req  = 1'b1;
               res_byte = LF_CHAR;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               end_req  = 1'b1;
               count_in = '0;
               skip_in  = SKIP_NONE;
               ended_in = 1'b0;
               final_in = 1'b0;
            end
         end
         default: begin
            shift = 1'b0;
         end
      endcase
   end

   // while flushing, one result is held back so the last can carry the end flag
   assign out_load = end_req || (res_req && (!final_ff || pend_valid_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         skip_ff       <= SKIP_NONE;
         ended_ff      <= 1'b0;
         final_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         ended_ff <= ended_in;
         final_ff <= final_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (end_req) begin
            pend_valid_ff <= 1'b0;
         end else if (res_req && final_ff) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_req && final_ff) begin
         pend_byte_ff <= res_byte;
      end
      if (end_req) begin
         rsp_byte_ff <= pend_valid_ff ? pend_byte_ff : NUL_CHAR;
         rsp_bv_ff   <= pend_valid_ff;
         rsp_eom_ff  <= 1'b1;
      end else if (out_load && final_ff) begin
         rsp_byte_ff <= pend_byte_ff;
         rsp_bv_ff   <= 1'b1;
         rsp_eom_ff  <= 1'b0;
      end else if (out_load) begin
         rsp_byte_ff <= res_byte;
         rsp_bv_ff   <= 1'b1;
         rsp_eom_ff  <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_byte_valid     = rsp_bv_ff;
   assign rsp_end_of_message = rsp_eom_ff;

endmodule
